/* src/ble_pkg.sv */
// ----------------------------------------------------------------------------
// ble_pkg: shared types and codes of the bounded list engine
// Operation codes, status codes, stream word layout and the control group
// that the top level broadcasts to every list cell.
// ----------------------------------------------------------------------------
package ble_pkg;

  // Operation codes carried in the mode field
  typedef enum logic [2:0] {
    MODE_ADD_FRONT = 3'd0,
    MODE_ADD_END   = 3'd1,
    MODE_RM_FRONT  = 3'd2,
    MODE_RM_END    = 3'd3,
    MODE_RM_MATCH  = 3'd4,
    MODE_QUERY     = 3'd5
  } mode_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NO_MATCH = 2'd3
  } status_e;

  // Field widths fixed by the word formats
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STATUS_W = 2;

  // Input word: mode, value, zero fill to whole bytes
  localparam int unsigned IN_BITS   = MODE_W + VALUE_W;
  localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

  // Output word: item_count, is_empty, front_value, found, status, zero fill
  localparam int unsigned OUT_BITS   = COUNT_W + 1 + VALUE_W + 1 + STATUS_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Bit positions in the output word
  localparam int unsigned OUT_EMPTY_B  = COUNT_W;
  localparam int unsigned OUT_FRONT_LO = COUNT_W + 1;
  localparam int unsigned OUT_FOUND_B  = OUT_FRONT_LO + VALUE_W;
  localparam int unsigned OUT_STAT_LO  = OUT_FOUND_B + 1;

  // Per-operation strobes sent to all cells (already qualified by accept)
  typedef struct packed {
    logic add_front;   // shift the whole row up, new item enters cell 0
    logic add_end;     // cell at position count loads the new item
    logic rm_front;    // shift the whole row down by one
    logic rm_match;    // cells at or after the first match shift down
  } cell_ctrl_t;

endpackage

/* src/ble_cell.sv */
// ----------------------------------------------------------------------------
// ble_cell: one slot of the list
// Holds a single item, compares it against the search key, extends the
// first-match chain and takes its next value from itself, a neighbor or
// the incoming item.
// ----------------------------------------------------------------------------
module ble_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned ITEM_WIDTH = 32,
  parameter int unsigned CNT_W      = 5
) (
  input  logic                  clk_i,
  input  ble_pkg::cell_ctrl_t   ctrl_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [ITEM_WIDTH-1:0] item_i,     // new item / search key
  input  logic [ITEM_WIDTH-1:0] lower_i,    // item of the cell below
  input  logic [ITEM_WIDTH-1:0] upper_i,    // item of the cell above
  input  logic                  match_i,    // a match at a lower position
  output logic                  match_o,    // a match here or lower
  output logic [ITEM_WIDTH-1:0] data_o,
  output logic [ITEM_WIDTH-1:0] next_o
);

  logic [ITEM_WIDTH-1:0] data_q, data_d;
  logic                  occupied;
  logic                  hit;

  // Occupancy and compare
  assign occupied = CNT_W'(IDX) < count_i;
  assign hit      = occupied && (data_q == item_i);
  assign match_o  = match_i | hit;

  // Next value select
  always_comb begin
    data_d = data_q;
    if (ctrl_i.add_front) begin
      data_d = lower_i;
    end else if (ctrl_i.add_end && (count_i == CNT_W'(IDX))) begin
      data_d = item_i;
    end else if (ctrl_i.rm_front || (ctrl_i.rm_match && match_o)) begin
      data_d = upper_i;
    end
  end

  // Payload storage, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign next_o = data_d;

endmodule

/* src/bounded_list_engine.sv */
// A result word is registered in the cycle after its input word is taken.
// Throughput: one word per cycle while no result word is stalled; the compare,
// first-match chain and shift select over all DEPTH cells are combinational.
// The first-match ripple through the cell row sets the critical path.
// Reset: the item count clears and the output goes invalid; items held in the
// cells are not cleared and are never read above the count.
// ----------------------------------------------------------------------------
// bounded_list_engine: ordered list of up to DEPTH items
// Add or remove at either end, remove the first equal item closing the gap,
// or query for an item. Every input word returns one status word.
// ----------------------------------------------------------------------------
module bounded_list_engine #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned ITEM_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input words
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [2:0] mode, [34:3] value, rest zero
  input  logic [ble_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // result words
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [4:0] item_count, [5] is_empty, [37:6] front_value, [38] found,
  // [40:39] status, rest zero
  output logic [ble_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned VW    = (ITEM_WIDTH < ble_pkg::VALUE_W) ? ITEM_WIDTH
                                                                  : ble_pkg::VALUE_W;

  logic                          accept;
  logic [ble_pkg::MODE_W-1:0]    mode;
  logic [ble_pkg::VALUE_W-1:0]   value;
  logic [ITEM_WIDTH-1:0]         item;
  logic [CNT_W-1:0]              count_q, count_d;
  logic                          full, empty, found;
  ble_pkg::status_e              status;
  ble_pkg::cell_ctrl_t           ctrl;
  logic                          out_valid_q;
  logic [ble_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic [ble_pkg::VALUE_W-1:0]   front;

  logic [ITEM_WIDTH-1:0]         cell_data [DEPTH];
  logic [ITEM_WIDTH-1:0]         cell_next [DEPTH];
  logic                          match_chain [DEPTH+1];

  // Input word unpack, item masked to the stored width
  assign mode  = s_axis_tdata_i[ble_pkg::MODE_W-1:0];
  assign value = s_axis_tdata_i[ble_pkg::IN_BITS-1:ble_pkg::MODE_W];
  assign item  = ITEM_WIDTH'(value[VW-1:0]);

  // Output register frees as soon as the pending word is taken
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);
  assign found = match_chain[DEPTH];

  // Operation decode
  always_comb begin
    ctrl    = '0;
    count_d = count_q;
    status  = ble_pkg::STAT_OK;
    unique case (mode)
      ble_pkg::MODE_ADD_FRONT: begin
        if (full) begin
          status = ble_pkg::STAT_FULL;
        end else begin
          ctrl.add_front = accept;
          count_d        = count_q + CNT_W'(1);
        end
      end
      ble_pkg::MODE_ADD_END: begin
        if (full) begin
          status = ble_pkg::STAT_FULL;
        end else begin
          ctrl.add_end = accept;
          count_d      = count_q + CNT_W'(1);
        end
      end
      ble_pkg::MODE_RM_FRONT: begin
        if (empty) begin
          status = ble_pkg::STAT_EMPTY;
        end else begin
          ctrl.rm_front = accept;
          count_d       = count_q - CNT_W'(1);
        end
      end
      ble_pkg::MODE_RM_END: begin
        if (empty) begin
          status = ble_pkg::STAT_EMPTY;
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
      ble_pkg::MODE_RM_MATCH: begin
        // no match means no cell shifts
        ctrl.rm_match = accept;
        if (empty) begin
          status = ble_pkg::STAT_EMPTY;
        end else if (!found) begin
          status = ble_pkg::STAT_NO_MATCH;
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Row of cells; cell 0 takes the new item from below
  assign match_chain[0] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [ITEM_WIDTH-1:0] lower, upper;
    if (g == 0) begin : g_first
      assign lower = item;
    end else begin : g_mid
      assign lower = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_inner
      assign upper = cell_data[g+1];
    end

    ble_cell #(
      .IDX        (g),
      .ITEM_WIDTH (ITEM_WIDTH),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .count_i (count_q),
      .item_i  (item),
      .lower_i (lower),
      .upper_i (upper),
      .match_i (match_chain[g]),
      .match_o (match_chain[g+1]),
      .data_o  (cell_data[g]),
      .next_o  (cell_next[g])
    );
  end

  // Result word from the state after this operation
  always_comb begin
    front      = (count_d == '0) ? '0 : ble_pkg::VALUE_W'(cell_next[0][VW-1:0]);
    out_data_d = '0;
    out_data_d[ble_pkg::COUNT_W-1:0]                       = ble_pkg::COUNT_W'(count_d);
    out_data_d[ble_pkg::OUT_EMPTY_B]                       = (count_d == '0);
    out_data_d[ble_pkg::OUT_FOUND_B-1:ble_pkg::OUT_FRONT_LO] = front;
    out_data_d[ble_pkg::OUT_FOUND_B] = found && ((mode == ble_pkg::MODE_RM_MATCH) ||
                                                 (mode == ble_pkg::MODE_QUERY));
    out_data_d[ble_pkg::OUT_STAT_LO +: ble_pkg::STATUS_W]  = status;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

/* src/ble_checker.sv */
// ----------------------------------------------------------------------------
// ble_checker: port-level checks for the bounded list engine
// Watches the stream ports and flags inconsistent result words.
// ----------------------------------------------------------------------------
module ble_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_tvalid_i,
  input logic                           m_tready_i,
  input logic [ble_pkg::OUT_DATA_W-1:0] m_tdata_i
);

  logic [ble_pkg::COUNT_W-1:0]  cnt;
  logic                         is_empty;
  logic [ble_pkg::VALUE_W-1:0]  front;
  logic                         found;
  logic [ble_pkg::STATUS_W-1:0] status;

  assign cnt      = m_tdata_i[ble_pkg::COUNT_W-1:0];
  assign is_empty = m_tdata_i[ble_pkg::OUT_EMPTY_B];
  assign front    = m_tdata_i[ble_pkg::OUT_FOUND_B-1:ble_pkg::OUT_FRONT_LO];
  assign found    = m_tdata_i[ble_pkg::OUT_FOUND_B];
  assign status   = m_tdata_i[ble_pkg::OUT_STAT_LO +: ble_pkg::STATUS_W];

  // No result word while in reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_tvalid_i)
    else $error("result valid during reset");

  // An empty list reports zero items and a zero front
  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_i && is_empty) |-> (cnt == '0 && front == '0))
    else $error("empty result with items or front value");

  // A found item never comes with an error status
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_i && found) |-> (status == ble_pkg::STAT_OK))
    else $error("found flag with error status");

  // A refused removal leaves the list empty
  a_rm_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_i && status == ble_pkg::STAT_EMPTY) |-> is_empty)
    else $error("remove-on-empty status with items held");

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_i && !m_tready_i) |=> (m_tvalid_i && $stable(m_tdata_i)))
    else $error("stalled result changed");

endmodule

bind bounded_list_engine ble_checker u_ble_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o)
);

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the bounded list engine
// Streams list operations into the block and keeps a shadow list that is
// updated on every accepted input word. Each result word is compared field
// by field with the oldest predicted result. The sender runs in random bursts
// and the receiver stalls on its own random pattern, including one long hold.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LIST_DEPTH = 16;
  // Mode codes outside the operation set; the block treats them as no-ops
  localparam logic [ble_pkg::MODE_W-1:0] MODE_NOP_LO = 3'd6;
  localparam logic [ble_pkg::MODE_W-1:0] MODE_NOP_HI = 3'd7;

  // One pending input word
  typedef struct packed {
    logic [ble_pkg::MODE_W-1:0]  mode;
    logic [ble_pkg::VALUE_W-1:0] value;
    logic                        wait_drain;  // hold off until all results are back
  } list_op_t;

  // One result word, split into fields
  typedef struct packed {
    logic [ble_pkg::COUNT_W-1:0] count;
    logic                        empty;
    logic [ble_pkg::VALUE_W-1:0] front;
    logic                        found;
    ble_pkg::status_e            status;
  } list_result_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b1;
  logic                           s_valid = 1'b0;
  logic [ble_pkg::IN_DATA_W-1:0]  s_data = '0;
  logic                           m_ready = 1'b0;
  logic                           s_axis_tready_o;
  logic                           m_axis_tvalid_o;
  logic [ble_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;

  list_op_t     pend_q[$];
  list_result_t result_q[$];

  // Shadow copy of the list
  logic [ble_pkg::VALUE_W-1:0] shadow_list[LIST_DEPTH];
  int                          shadow_cnt = 0;

  int err_count    = 0;
  int results_seen = 0;
  bit word_taken   = 1'b0;

  always #5 clk_i = ~clk_i;

  bounded_list_engine #(
    .DEPTH      (LIST_DEPTH),
    .ITEM_WIDTH (ble_pkg::VALUE_W)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Remove the shadow entry at pos and close the gap
  function automatic void drop_shadow(input int pos);
    int i;
    for (i = pos; i + 1 < shadow_cnt; i++) shadow_list[i] = shadow_list[i + 1];
    shadow_cnt--;
  endfunction

  // Apply one operation to the shadow list and return the expected result
  function automatic list_result_t apply_list_op(
    input logic [ble_pkg::MODE_W-1:0]  mode,
    input logic [ble_pkg::VALUE_W-1:0] value
  );
    list_result_t r;
    int           hit;
    int           i;
    r.found  = 1'b0;
    r.status = ble_pkg::STAT_OK;
    hit      = -1;
    for (i = 0; i < shadow_cnt; i++)
      if (hit < 0 && shadow_list[i] == value) hit = i;
    case (mode)
      ble_pkg::MODE_ADD_FRONT: begin
        if (shadow_cnt >= LIST_DEPTH) begin
          r.status = ble_pkg::STAT_FULL;
        end else begin
          for (i = shadow_cnt; i > 0; i--) shadow_list[i] = shadow_list[i - 1];
          shadow_list[0] = value;
          shadow_cnt++;
        end
      end
      ble_pkg::MODE_ADD_END: begin
        if (shadow_cnt >= LIST_DEPTH) begin
          r.status = ble_pkg::STAT_FULL;
        end else begin
          shadow_list[shadow_cnt] = value;
          shadow_cnt++;
        end
      end
      ble_pkg::MODE_RM_FRONT: begin
        if (shadow_cnt == 0) r.status = ble_pkg::STAT_EMPTY;
        else drop_shadow(0);
      end
      ble_pkg::MODE_RM_END: begin
        if (shadow_cnt == 0) r.status = ble_pkg::STAT_EMPTY;
        else shadow_cnt--;
      end
      ble_pkg::MODE_RM_MATCH: begin
        if (shadow_cnt == 0) begin
          r.status = ble_pkg::STAT_EMPTY;
        end else if (hit < 0) begin
          r.status = ble_pkg::STAT_NO_MATCH;
        end else begin
          drop_shadow(hit);
          r.found = 1'b1;
        end
      end
      ble_pkg::MODE_QUERY: begin
        r.found = (hit >= 0);
      end
      default: ;
    endcase
    r.count = shadow_cnt[ble_pkg::COUNT_W-1:0];
    r.empty = (shadow_cnt == 0);
    r.front = (shadow_cnt == 0) ? '0 : shadow_list[0];
    return r;
  endfunction

  function automatic void check_field(input string fname,
                                      input logic [ble_pkg::VALUE_W-1:0] want,
                                      input logic [ble_pkg::VALUE_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, actual %0h", $time, fname, want, got);
      err_count++;
    end
  endfunction

  // Input acceptance feeds the shadow list; result words are checked in order
  always @(posedge clk_i) begin
    list_result_t want;
    list_result_t got;
    word_taken = 1'b0;
    if (rst_ni) begin
      if (s_valid && s_axis_tready_o) begin
        result_q.push_back(apply_list_op(s_data[ble_pkg::MODE_W-1:0],
                                         s_data[ble_pkg::MODE_W +: ble_pkg::VALUE_W]));
        void'(pend_q.pop_front());
        word_taken = 1'b1;
      end
      if (m_axis_tvalid_o && m_ready) begin
        results_seen++;
        got.count  = m_axis_tdata_o[ble_pkg::COUNT_W-1:0];
        got.empty  = m_axis_tdata_o[ble_pkg::OUT_EMPTY_B];
        got.front  = m_axis_tdata_o[ble_pkg::OUT_FRONT_LO +: ble_pkg::VALUE_W];
        got.found  = m_axis_tdata_o[ble_pkg::OUT_FOUND_B];
        got.status = ble_pkg::status_e'(
                       m_axis_tdata_o[ble_pkg::OUT_STAT_LO +: ble_pkg::STATUS_W]);
        if (result_q.size() == 0) begin
          $display("%0t: result word with none expected, actual %0h", $time,
                   m_axis_tdata_o);
          err_count++;
        end else begin
          want = result_q.pop_front();
          check_field("item_count", ble_pkg::VALUE_W'(want.count),
                      ble_pkg::VALUE_W'(got.count));
          check_field("is_empty", ble_pkg::VALUE_W'(want.empty),
                      ble_pkg::VALUE_W'(got.empty));
          check_field("front_value", want.front, got.front);
          check_field("found", ble_pkg::VALUE_W'(want.found),
                      ble_pkg::VALUE_W'(got.found));
          check_field("status", ble_pkg::VALUE_W'(want.status),
                      ble_pkg::VALUE_W'(got.status));
        end
      end
    end
  end

  // Sender: random bursts and gaps, optional drain before a marked word
  always @(negedge clk_i) begin
    static int burst_left = 0;
    static int gap_left   = 0;
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else if (s_valid && !word_taken) begin
      // hold the offered word
    end else if (gap_left > 0) begin
      gap_left--;
      s_valid <= 1'b0;
    end else if (pend_q.size() == 0) begin
      s_valid <= 1'b0;
    end else if (pend_q[0].wait_drain && result_q.size() != 0) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= 1'b1;
      s_data  <= ble_pkg::IN_DATA_W'({pend_q[0].value, pend_q[0].mode});
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 40);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
    end
  end

  // Receiver: its own stall pattern plus one long hold to back up the block
  always @(negedge clk_i) begin
    static int  hold_left  = 0;
    static int  phase_left = 0;
    static int  rdy_style  = 0;
    static bit  held_once  = 1'b0;
    logic       rdy;
    if (!held_once && results_seen >= 150) begin
      held_once = 1'b1;
      hold_left = 120;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else begin
      if (phase_left == 0) begin
        rdy_style  = $urandom_range(0, 2);
        phase_left = $urandom_range(20, 80);
      end
      phase_left--;
      case (rdy_style)
        0:       rdy = 1'b1;
        1:       rdy = ($urandom_range(0, 3) != 0);
        default: rdy = ($urandom_range(0, 3) == 0);
      endcase
    end
    m_ready <= rdy;
  end

  task automatic queue_op(input logic [ble_pkg::MODE_W-1:0] mode,
                          input logic [ble_pkg::VALUE_W-1:0] value,
                          input logic wait_drain);
    list_op_t op;
    op.mode       = mode;
    op.value      = value;
    op.wait_drain = wait_drain;
    pend_q.push_back(op);
  endtask

  // Stimulus, reset and end of run
  initial begin
    logic [ble_pkg::VALUE_W-1:0] value_pool[6];
    logic [ble_pkg::MODE_W-1:0]  mode;
    logic [ble_pkg::VALUE_W-1:0] value;
    int                          add_pct;
    int                          r;
    int                          n;
    // reset falls after time zero so the asynchronous clear always fires
    #1 rst_ni = 1'b0;
    value_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                   32'h8000_0000, 32'hA5A5_A5A5, 32'h5A5A_5A5A};

    // Directed: empty list cases, no-op modes, fill to full, refusals
    queue_op(ble_pkg::MODE_QUERY, 32'h0, 1'b0);
    queue_op(ble_pkg::MODE_RM_FRONT, 32'h0, 1'b0);
    queue_op(ble_pkg::MODE_RM_END, 32'h0, 1'b0);
    queue_op(ble_pkg::MODE_RM_MATCH, 32'h0, 1'b0);
    queue_op(MODE_NOP_LO, 32'hFFFF_FFFF, 1'b0);
    queue_op(MODE_NOP_HI, 32'h0, 1'b0);
    queue_op(ble_pkg::MODE_ADD_END, 32'hFFFF_FFFF, 1'b0);
    queue_op(ble_pkg::MODE_ADD_FRONT, 32'h0, 1'b0);
    queue_op(ble_pkg::MODE_QUERY, 32'hFFFF_FFFF, 1'b0);
    queue_op(ble_pkg::MODE_RM_MATCH, 32'h1234_5678, 1'b0);
    for (n = 0; n < 14; n++)
      queue_op(ble_pkg::MODE_ADD_END, 32'h1111_1111 * (n % 7), 1'b0);
    queue_op(ble_pkg::MODE_ADD_FRONT, 32'hDEAD_BEEF, 1'b0);
    queue_op(ble_pkg::MODE_ADD_END, 32'hDEAD_BEEF, 1'b0);
    queue_op(ble_pkg::MODE_RM_MATCH, 32'h2222_2222, 1'b0);

    // Random: phases that favor filling, draining, or neither
    add_pct = 50;
    for (n = 0; n < 800; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       add_pct = 70;
          1:       add_pct = 30;
          default: add_pct = 50;
        endcase
      end
      if ($urandom_range(0, 3) != 0) value = value_pool[$urandom_range(0, 5)];
      else value = $urandom;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        mode = (r == 0) ? MODE_NOP_HI : MODE_NOP_LO;
      end else if (r < add_pct) begin
        mode = r[0] ? ble_pkg::MODE_ADD_FRONT : ble_pkg::MODE_ADD_END;
      end else begin
        case ($urandom_range(0, 3))
          0:       mode = ble_pkg::MODE_RM_FRONT;
          1:       mode = ble_pkg::MODE_RM_END;
          2:       mode = ble_pkg::MODE_RM_MATCH;
          default: mode = ble_pkg::MODE_QUERY;
        endcase
      end
      queue_op(mode, value, (n == 300 || n == 600));
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pend_q.size() != 0 || result_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_count == 0) $display("bounded_list_engine: match");
    else $display("bounded_list_engine: mismatch");
    $finish;
  end

  // Run limit
  initial begin
    #3000000;
    $display("bounded_list_engine: mismatch");
    $finish;
  end

endmodule

/* files.f */
src/ble_pkg.sv
src/ble_cell.sv
src/bounded_list_engine.sv
src/ble_checker.sv
tb/tb_top.sv
